@@ rtl/itrd_pkg.sv @@
// ----------------------------------------------------------------------------
// itrd_pkg
// Shared types, widths and helpers for the integer to radix digit converter.
// ----------------------------------------------------------------------------
package itrd_pkg;

  localparam int MAX_DIGITS_DEF = 32;
  localparam int VALUE_BITS_DEF = 32;

  localparam int RADIX_W       = 5;
  localparam int DIGIT_W       = 4;
  localparam int CHAR_W        = 7;
  // quotient bits resolved per divider cycle
  localparam int DIV_STEP_BITS = 4;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

  localparam logic [DIGIT_W-1:0] DIGIT_TEN   = 4'd10;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'd48;
  localparam logic [CHAR_W-1:0]  CHAR_ALPHA  = 7'd55;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_READ,
    S_LOAD
  } state_t;

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    if (r < RADIX_MIN) begin
      return RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      return RADIX_MAX;
    end
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    if (d < DIGIT_TEN) begin
      return CHAR_ZERO + CHAR_W'(d);
    end
    return CHAR_ALPHA + CHAR_W'(d);
  endfunction

endpackage

@@ rtl/itrd_ram.sv @@
// ----------------------------------------------------------------------------
// itrd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module itrd_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds until the next read
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/itrd_div.sv @@
// ----------------------------------------------------------------------------
// itrd_div
// Iterative divider by a small radix: several quotient bits per cycle,
// remainder kept below the radix so every step is a narrow compare/subtract.
// ----------------------------------------------------------------------------
module itrd_div #(
  parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [VALUE_BITS-1:0]         dividend,
  input  logic [itrd_pkg::RADIX_W-1:0]  radix,
  output logic                          done,
  output logic [VALUE_BITS-1:0]         quotient,
  output logic [itrd_pkg::DIGIT_W-1:0]  remainder
);

  import itrd_pkg::*;

  localparam int STEPS  = (VALUE_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
  localparam int PAD    = STEPS * DIV_STEP_BITS;
  localparam int STEP_W = $clog2(STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

  logic [PAD-1:0]           dq_r, dq_nxt;
  logic [DIGIT_W-1:0]       rem_r, rem_nxt;
  logic [RADIX_W-1:0]       radix_r;
  logic [STEP_W-1:0]        step_r;
  logic                     busy_r;
  logic                     done_r;
  logic [DIV_STEP_BITS-1:0] qbits;
  logic [RADIX_W-1:0]       acc;

  // dividend shifts out at the top, quotient bits shift in at the bottom
  always_comb begin
    acc     = '0;
    rem_nxt = rem_r;
    qbits   = '0;
    for (int i = 0; i < DIV_STEP_BITS; i++) begin
      acc = {rem_nxt, dq_r[PAD-1-i]};
      if (acc >= radix_r) begin
        acc = acc - radix_r;
        qbits[DIV_STEP_BITS-1-i] = 1'b1;
      end
      rem_nxt = acc[DIGIT_W-1:0];
    end
    dq_nxt = {dq_r[PAD-DIV_STEP_BITS-1:0], qbits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + 1'b1;
      if (step_r == LAST_STEP) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq_r    <= PAD'(dividend);
      rem_r   <= '0;
      radix_r <= radix;
    end else if (busy_r) begin
      dq_r    <= dq_nxt;
      rem_r   <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = dq_r[VALUE_BITS-1:0];
  assign remainder = rem_r;

endmodule

@@ rtl/integer_to_radix_digits_top.sv @@
// ----------------------------------------------------------------------------
// integer_to_radix_digits_top
// Converts an unsigned integer into digits of a configurable radix.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall / in_value): one unsigned integer per
// transaction. in_stall is high from acceptance until the last digit has been
// loaded into the output register, and while a config write is pending.
// Output channel (out_valid / out_stall / out_*): one transaction per digit,
// most significant first, with its value, uppercase ASCII code and a flag on
// the final digit. A zero input gives the single digit 0.
// Config channel (cfg_valid / cfg_ready / cfg_radix): sets the radix; values
// below 2 act as 2, above 16 as 16. cfg_ready is high while no item is active
// and the output register is empty.
// Conversion: the iterative divider (4 quotient bits per cycle) yields one
// digit as the remainder and is restarted on the quotient for the next digit
// until the quotient is zero or the digit memory is full. Each digit is then
// read back from the digit memory through the S_READ and S_LOAD states, and
// the readout waits on any output stall.
// Reset (synchronous, rst_n low) sets the radix to 10 and clears all control
// state; the digit memory needs no clearing. While out_stall is high with a
// digit valid, the current digit holds and the readout pauses.
// ----------------------------------------------------------------------------
module integer_to_radix_digits_top #(
  parameter int MAX_DIGITS = itrd_pkg::MAX_DIGITS_DEF,
  parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [VALUE_BITS-1:0]        in_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [itrd_pkg::DIGIT_W-1:0] out_digit,
  output logic [itrd_pkg::CHAR_W-1:0]  out_digit_char,
  output logic                         out_last_digit,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [itrd_pkg::RADIX_W-1:0] cfg_radix
);

  import itrd_pkg::*;

  localparam int AW    = $clog2(MAX_DIGITS);
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MAX_DIGITS - 1);
  localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_dec;
  logic [RADIX_W-1:0]  radix_r, eff_radix;

  logic                out_valid_r;
  logic [DIGIT_W-1:0]  out_digit_r;
  logic [CHAR_W-1:0]   out_char_r;
  logic                out_last_r;

  logic                div_start, div_done;
  logic [VALUE_BITS-1:0] div_dividend, div_quot;
  logic [DIGIT_W-1:0]  div_rem;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [DIGIT_W-1:0]  ram_rdata;

  logic                in_take, div_stop, out_free, out_load;

  assign eff_radix = clamp_radix(radix_r);
  assign count_dec = count_r - 1'b1;
  // a pending config write goes first
  assign in_take   = (state_r == S_IDLE) && in_valid && !cfg_valid;
  // digits run out, or the stack is full
  assign div_stop  = (div_quot == '0) || (count_r == LAST_CNT);
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done && div_stop) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          state_nxt = (count_r == ONE_CNT) ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall     = (state_r != S_IDLE) || cfg_valid;
    cfg_ready    = (state_r == S_IDLE) && !out_valid_r;
    div_start    = in_take || ((state_r == S_DIV) && div_done && !div_stop);
    div_dividend = (state_r == S_IDLE) ? in_value : div_quot;
    ram_we       = (state_r == S_DIV) && div_done;
    ram_waddr    = count_r[AW-1:0];
    ram_re       = (state_r == S_READ);
    ram_raddr    = count_dec[AW-1:0];
    out_load     = (state_r == S_LOAD) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      radix_r     <= RADIX_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        radix_r <= cfg_radix;
      end
      if (in_take) begin
        count_r <= '0;
      end else if (ram_we) begin
        count_r <= count_r + 1'b1;
      end else if (out_load) begin
        count_r <= count_dec;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_digit_r <= ram_rdata;
      out_char_r  <= digit_to_char(ram_rdata);
      out_last_r  <= (count_r == ONE_CNT);
    end
  end

  itrd_div #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .radix     (eff_radix),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  itrd_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_digit_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (div_rem),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid      = out_valid_r;
  assign out_digit      = out_digit_r;
  assign out_digit_char = out_char_r;
  assign out_last_digit = out_last_r;

endmodule
